// ===== hw/rtl/v3alu_pkg.sv =====
// shared constants, opcode codes and the carry record of the vector unit pipeline
// no dependencies; used by v3alu_root_pipe and vector3_alu_unit
package v3alu_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int DATA_W        = 32;
   localparam int SQRT_STEPS    = 32;
   localparam logic [DATA_W-1:0] MAX_POS = 32'h7fff_ffff;

   typedef enum logic [3:0] {
      OP_ADD       = 4'd0,
      OP_SUB       = 4'd1,
      OP_SCALE     = 4'd2,
      OP_ELEMMUL   = 4'd3,
      OP_DOT       = 4'd4,
      OP_CROSS     = 4'd5,
      OP_LENGTH    = 4'd6,
      OP_NORMALISE = 4'd7,
      OP_PROJECT   = 4'd8,
      OP_DISTANCE  = 4'd9,
      OP_LERP      = 4'd10
   } opcode_type;

   // everything one item carries through the root and divide stages
   typedef struct packed {
      opcode_type             opcode;
      logic [DATA_W-1:0]      rx;
      logic [DATA_W-1:0]      ry;
      logic [DATA_W-1:0]      rz;
      logic [DATA_W-1:0]      rw;
      logic [DATA_W-1:0]      sc;
      logic                   sat;
      logic                   huge;
      logic [2:0]             neg;
      logic [2:0][DATA_W-1:0] mag;
      logic [63:0]            n;
      logic [63:0]            r;
      logic [2:0][DATA_W-1:0] rem;
      logic [2:0][DATA_W-1:0] quo;
   } carry_type;

endpackage

// ===== hw/rtl/vector3_alu_unit.sv =====
// three-component fixed-point vector unit: top level with operand, multiply, combine
// and saturate stages; depends on v3alu_pkg and v3alu_root_pipe
//
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | tuser opcode, tdata a, a_w, b, b_w, scalar_in
//  rsp     | out | rsp_tvalid/rsp_tready | tdata r, r_w, scalar_out, tuser flags
//
// one item a cycle while the result side is not stalled; the pipeline holds the 32 square-root
// stages and the FRAC_BITS+1 divide stages
// reset is synchronous and clears only the valid bits; no item is taken during reset
// a stalled result holds the whole pipeline; nothing is dropped or repeated
module vector3_alu_unit import v3alu_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [287:0] req_tdata,  // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar_in
   input  logic [3:0]   req_tuser,  // opcode
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [159:0] rsp_tdata,  // r_x, r_y, r_z, r_w, scalar_out
   output logic [1:0]   rsp_tuser   // saturated, zero_length
);

   localparam int OPND_W = DATA_W + 1;
   localparam int PROD_W = 2 * OPND_W;
   localparam int BASE_W = DATA_W + 2;
   localparam int WIDE_W = PROD_W + 2;

   typedef struct packed {
      opcode_type             opcode;
      logic [2:0][DATA_W-1:0] av;
      logic [2:0][DATA_W-1:0] bv;
      logic [DATA_W-1:0]      aw;
      logic [DATA_W-1:0]      bw;
      logic [DATA_W-1:0]      s;
   } in_type;

   typedef struct packed {
      opcode_type             opcode;
      logic [6:0][OPND_W-1:0] opa;
      logic [6:0][OPND_W-1:0] opb;
      logic [2:0][BASE_W-1:0] base;
      logic [2:0]             neg;
      logic [2:0][DATA_W-1:0] mag;
      logic                   huge;
   } opnd_type;

   typedef struct packed {
      opcode_type             opcode;
      logic [6:0][PROD_W-1:0] prod;
      logic [2:0][BASE_W-1:0] base;
      logic [2:0]             neg;
      logic [2:0][DATA_W-1:0] mag;
      logic                   huge;
   } prod_type;

   typedef struct packed {
      opcode_type             opcode;
      logic [4:0][WIDE_W-1:0] wide;
      logic [63:0]            sumsq;
      logic [2:0]             neg;
      logic [2:0][DATA_W-1:0] mag;
      logic                   huge;
   } comb_type;

   typedef struct packed {
      logic [DATA_W-1:0] rx;
      logic [DATA_W-1:0] ry;
      logic [DATA_W-1:0] rz;
      logic [DATA_W-1:0] rw;
      logic [DATA_W-1:0] sc;
      logic              sat;
      logic              zl;
   } out_type;

   function automatic logic [OPND_W-1:0] ext_op(input logic [DATA_W-1:0] v);
      return {v[DATA_W-1], v};
   endfunction

   function automatic logic [BASE_W-1:0] ext_base(input logic [DATA_W-1:0] v);
      return {{2{v[DATA_W-1]}}, v};
   endfunction

   // msb is the clamp flag
   function automatic logic [DATA_W:0] sat_word(input logic [WIDE_W-1:0] v);
      logic ovf;
      ovf = (v[WIDE_W-1:DATA_W-1] != '0) && (v[WIDE_W-1:DATA_W-1] != '1);
      if (ovf) begin
         return {1'b1, v[WIDE_W-1] ? ~MAX_POS : MAX_POS};
      end
      return {1'b0, v[DATA_W-1:0]};
   endfunction

   logic      en;
   in_type    s0_ff, s0_in;
   opnd_type  s1_ff, s1_in;
   prod_type  s2_ff, s2_in;
   comb_type  s3_ff, s3_in;
   carry_type s4_ff, s4_in;
   logic      v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;
   logic      root_valid;
   carry_type root_item;
   out_type   rsp_ff, rsp_in;
   logic      rsp_vld_ff;

   assign en         = !rsp_vld_ff || rsp_tready;
   assign req_tready = en && !reset;

   always_comb begin
      s0_in.opcode = opcode_type'(req_tuser);
      for (int i = 0; i < 3; i++) begin
         s0_in.av[i] = req_tdata[DATA_W*i +: DATA_W];
         s0_in.bv[i] = req_tdata[DATA_W*(i+4) +: DATA_W];
      end
      s0_in.aw = req_tdata[DATA_W*3 +: DATA_W];
      s0_in.bw = req_tdata[DATA_W*7 +: DATA_W];
      s0_in.s  = req_tdata[DATA_W*8 +: DATA_W];
   end

   // operand selection for the seven multiplier lanes
   always_comb begin
      logic [2:0][OPND_W-1:0] d;
      logic [2:0]             big;
      s1_in = '0;
      s1_in.opcode = s0_ff.opcode;
      for (int i = 0; i < 3; i++) begin
         d[i]   = ext_op(s0_ff.bv[i]) - ext_op(s0_ff.av[i]);
         big[i] = (d[i][OPND_W-1] != d[i][OPND_W-2]) || (d[i] == {2'b11, {(DATA_W-1){1'b0}}});
         s1_in.neg[i] = s0_ff.av[i][DATA_W-1];
         s1_in.mag[i] = s0_ff.av[i][DATA_W-1] ? (~s0_ff.av[i] + 1'b1) : s0_ff.av[i];
      end
      s1_in.huge   = |big;
      s1_in.opa[6] = ext_op(s0_ff.aw);
      s1_in.opb[6] = ext_op(s0_ff.bw);
      case (s0_ff.opcode)
         OP_ADD: begin
            for (int i = 0; i < 3; i++) begin
               s1_in.base[i] = ext_base(s0_ff.av[i]) + ext_base(s0_ff.bv[i]);
            end
         end
         OP_SUB: begin
            for (int i = 0; i < 3; i++) begin
               s1_in.base[i] = ext_base(s0_ff.av[i]) - ext_base(s0_ff.bv[i]);
            end
         end
         OP_SCALE: begin
            for (int i = 0; i < 3; i++) begin
               s1_in.opa[i] = ext_op(s0_ff.av[i]);
               s1_in.opb[i] = ext_op(s0_ff.s);
            end
         end
         OP_ELEMMUL, OP_DOT: begin
            for (int i = 0; i < 3; i++) begin
               s1_in.opa[i] = ext_op(s0_ff.av[i]);
               s1_in.opb[i] = ext_op(s0_ff.bv[i]);
            end
         end
         OP_CROSS: begin
            s1_in.opa[0] = ext_op(s0_ff.av[1]); s1_in.opb[0] = ext_op(s0_ff.bv[2]);
            s1_in.opa[1] = ext_op(s0_ff.av[2]); s1_in.opb[1] = ext_op(s0_ff.bv[0]);
            s1_in.opa[2] = ext_op(s0_ff.av[0]); s1_in.opb[2] = ext_op(s0_ff.bv[1]);
            s1_in.opa[3] = ext_op(s0_ff.av[2]); s1_in.opb[3] = ext_op(s0_ff.bv[1]);
            s1_in.opa[4] = ext_op(s0_ff.av[0]); s1_in.opb[4] = ext_op(s0_ff.bv[2]);
            s1_in.opa[5] = ext_op(s0_ff.av[1]); s1_in.opb[5] = ext_op(s0_ff.bv[0]);
         end
         OP_LENGTH, OP_NORMALISE: begin
            for (int i = 0; i < 3; i++) begin
               s1_in.opa[i] = ext_op(s0_ff.av[i]);
               s1_in.opb[i] = ext_op(s0_ff.av[i]);
            end
         end
         OP_PROJECT: begin
            for (int i = 0; i < 3; i++) begin
               s1_in.base[i] = ext_base(s0_ff.av[i]);
               s1_in.opa[i]  = ext_op(s0_ff.bv[i]);
               s1_in.opb[i]  = ext_op(s0_ff.s);
            end
         end
         OP_DISTANCE: begin
            for (int i = 0; i < 3; i++) begin
               s1_in.opa[i] = d[i];
               s1_in.opb[i] = d[i];
            end
         end
         OP_LERP: begin
            for (int i = 0; i < 3; i++) begin
               s1_in.base[i] = ext_base(s0_ff.av[i]);
               s1_in.opa[i]  = d[i];
               s1_in.opb[i]  = ext_op(s0_ff.s);
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      s2_in.opcode = s1_ff.opcode;
      s2_in.base   = s1_ff.base;
      s2_in.neg    = s1_ff.neg;
      s2_in.mag    = s1_ff.mag;
      s2_in.huge   = s1_ff.huge;
      for (int i = 0; i < 7; i++) begin
         s2_in.prod[i] = PROD_W'($signed(s1_ff.opa[i]) * $signed(s1_ff.opb[i]));
      end
   end

   // rescale by FRAC_BITS (floor) and combine per opcode; the dot product sums across components
   always_comb begin
      logic [6:0][WIDE_W-1:0] t;
      logic [2:0][WIDE_W-1:0] bw;
      for (int i = 0; i < 7; i++) begin
         t[i] = WIDE_W'($signed(s2_ff.prod[i]) >>> FRAC_BITS);
      end
      for (int i = 0; i < 3; i++) begin
         bw[i] = WIDE_W'($signed(s2_ff.base[i]));
      end
      s3_in.opcode = s2_ff.opcode;
      s3_in.neg    = s2_ff.neg;
      s3_in.mag    = s2_ff.mag;
      s3_in.huge   = s2_ff.huge;
      s3_in.sumsq  = s2_ff.prod[0][63:0] + s2_ff.prod[1][63:0] + s2_ff.prod[2][63:0];
      s3_in.wide   = '0;
      case (s2_ff.opcode)
         OP_ADD, OP_SUB: begin
            for (int i = 0; i < 3; i++) s3_in.wide[i] = bw[i];
         end
         OP_SCALE, OP_ELEMMUL, OP_PROJECT: begin
            for (int i = 0; i < 3; i++) s3_in.wide[i] = bw[i] + t[i];
         end
         OP_LERP: begin
            for (int i = 0; i < 3; i++) s3_in.wide[i] = bw[i] + t[i];
            s3_in.wide[3] = t[6];
         end
         OP_CROSS: begin
            for (int i = 0; i < 3; i++) s3_in.wide[i] = t[i] - t[i+3];
         end
         OP_DOT: begin
            s3_in.wide[4] = t[0] + t[1] + t[2];
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      logic [4:0][DATA_W:0] sw;
      for (int i = 0; i < 5; i++) sw[i] = sat_word(s3_ff.wide[i]);
      s4_in        = '0;
      s4_in.opcode = s3_ff.opcode;
      s4_in.rx     = sw[0][DATA_W-1:0];
      s4_in.ry     = sw[1][DATA_W-1:0];
      s4_in.rz     = sw[2][DATA_W-1:0];
      s4_in.rw     = sw[3][DATA_W-1:0];
      s4_in.sc     = sw[4][DATA_W-1:0];
      s4_in.sat    = sw[0][DATA_W] | sw[1][DATA_W] | sw[2][DATA_W] | sw[3][DATA_W] |
                     sw[4][DATA_W];
      s4_in.huge   = s3_ff.huge;
      s4_in.neg    = s3_ff.neg;
      s4_in.mag    = s3_ff.mag;
      s4_in.n      = s3_ff.sumsq;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_tvalid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_ff <= s0_in;
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
      end
   end

   v3alu_root_pipe #(
      .FRAC_BITS (FRAC_BITS)
   ) u_root (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v4_ff),
      .in_item   (s4_ff),
      .out_valid (root_valid),
      .out_item  (root_item)
   );

   // fold in the root and quotients for the length-type opcodes
   always_comb begin
      logic [DATA_W-1:0] len;
      logic [2:0][DATA_W-1:0] nv;
      len = root_item.r[DATA_W-1:0];
      for (int i = 0; i < 3; i++) begin
         nv[i] = root_item.neg[i] ? (~root_item.quo[i] + 1'b1) : root_item.quo[i];
      end
      rsp_in.rx  = root_item.rx;
      rsp_in.ry  = root_item.ry;
      rsp_in.rz  = root_item.rz;
      rsp_in.rw  = root_item.rw;
      rsp_in.sc  = root_item.sc;
      rsp_in.sat = root_item.sat;
      rsp_in.zl  = 1'b0;
      case (root_item.opcode)
         OP_LENGTH: begin
            rsp_in.sc  = len[DATA_W-1] ? MAX_POS : len;
            rsp_in.sat = len[DATA_W-1];
         end
         OP_DISTANCE: begin
            rsp_in.sc  = (root_item.huge || len[DATA_W-1]) ? MAX_POS : len;
            rsp_in.sat = root_item.huge || len[DATA_W-1];
         end
         OP_NORMALISE: begin
            if (len == '0) begin
               rsp_in.zl = 1'b1;
            end else begin
               rsp_in.sc  = len[DATA_W-1] ? MAX_POS : len;
               rsp_in.sat = len[DATA_W-1];
               rsp_in.rx  = nv[0];
               rsp_in.ry  = nv[1];
               rsp_in.rz  = nv[2];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= root_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {rsp_ff.sc, rsp_ff.rw, rsp_ff.rz, rsp_ff.ry, rsp_ff.rx};
   assign rsp_tuser  = {rsp_ff.zl, rsp_ff.sat};

endmodule

// ===== hw/rtl/v3alu_root_pipe.sv =====
// integer square root (one result bit a stage) followed by three restoring dividers
// (one quotient bit a stage); depends on v3alu_pkg
module v3alu_root_pipe import v3alu_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  logic      in_valid,
   input  carry_type in_item,
   output logic      out_valid,
   output carry_type out_item
);

   localparam int DIV_STEPS = FRAC_BITS + 1;
   localparam int NSTG      = SQRT_STEPS + DIV_STEPS;

   carry_type         stg_ff [NSTG];
   logic [NSTG-1:0]   vld_ff;

   for (genvar k = 0; k < NSTG; k++) begin : g_stage
      carry_type prev;
      carry_type nxt;
      logic      pv;

      if (k == 0) begin : g_first
         assign prev = in_item;
         assign pv   = in_valid;
      end else begin : g_next
         assign prev = stg_ff[k-1];
         assign pv   = vld_ff[k-1];
      end

      if (k < SQRT_STEPS) begin : g_sqrt
         localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
         logic [63:0] trial;
         assign trial = prev.r + BIT;
         always_comb begin
            nxt = prev;
            if (prev.n >= trial) begin
               nxt.n = prev.n - trial;
               nxt.r = (prev.r >> 1) + BIT;
            end else begin
               nxt.r = prev.r >> 1;
            end
         end
      end else begin : g_div
         logic [DATA_W:0] len;
         logic [2:0][DATA_W:0] rem_in;
         logic [2:0] ge;
         assign len = {1'b0, prev.r[DATA_W-1:0]};
         for (genvar i = 0; i < 3; i++) begin : g_lane
            if (k == SQRT_STEPS) begin : g_load
               assign rem_in[i] = {1'b0, prev.mag[i]};
            end else begin : g_shift
               assign rem_in[i] = {prev.rem[i], 1'b0};
            end
            assign ge[i] = rem_in[i] >= len;
         end
         always_comb begin
            nxt = prev;
            for (int i = 0; i < 3; i++) begin
               nxt.rem[i] = ge[i] ? DATA_W'(rem_in[i] - len) : rem_in[i][DATA_W-1:0];
               nxt.quo[i] = {prev.quo[i][DATA_W-2:0], ge[i]};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            stg_ff[k] <= nxt;
         end
      end
   end

   assign out_valid = vld_ff[NSTG-1];
   assign out_item  = stg_ff[NSTG-1];

endmodule

// ===== verif/vector3_alu_unit_test.sv =====
// testbench for the fixed-point vector unit: table of directed items, then random items,
// every result checked against a behavioural predictor; depends on v3alu_pkg and the rtl
module vector3_alu_unit_test;
   import v3alu_pkg::*;

   localparam int FB        = 16;
   localparam int N_RANDOM  = 1530;
   localparam int MAX_CYC   = 400000;
   localparam longint P_MAX = 64'sd2147483647;
   localparam longint N_MIN = -64'sd2147483648;

   typedef struct {
      logic [3:0] code;
      logic signed [31:0] ax, ay, az, aw, bx, by, bz, bw, s;
   } vec_item_type;

   typedef struct packed {
      logic signed [31:0] rx;
      logic signed [31:0] ry;
      logic signed [31:0] rz;
      logic signed [31:0] rw;
      logic signed [31:0] sc;
      logic sat;
      logic zl;
   } vec_result_type;

   typedef struct {
      vec_item_type it;
      bit typed;
      vec_result_type res;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [287:0] req_tdata = '0;  // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar_in
   logic [3:0] req_tuser = '0;    // opcode
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [159:0] rsp_tdata;       // r_x, r_y, r_z, r_w, scalar_out
   logic [1:0] rsp_tuser;         // saturated, zero_length

   vec_result_type expected_q[$];
   int error_count = 0;
   int cycle_count = 0;
   bit sink_calm = 1'b0;

   vector3_alu_unit #(.FRAC_BITS(FB)) i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYC) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic longint clamp32(longint v, inout bit sat);
      if (v > P_MAX) begin
         sat = 1'b1;
         return P_MAX;
      end
      if (v < N_MIN) begin
         sat = 1'b1;
         return N_MIN;
      end
      return v;
   endfunction

   // >>> on a signed longint floors, as the hardware does
   function automatic longint qmul(longint x, longint y);
      longint p;
      p = x * y;
      return p >>> FB;
   endfunction

   function automatic longint unsigned root64(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint unsigned norm3(longint x, longint y, longint z);
      longint unsigned q;
      q = longint'(x * x) + longint'(y * y) + longint'(z * z);
      return root64(q);
   endfunction

   function automatic longint unit_div(longint c, longint unsigned len, inout bit sat);
      longint unsigned m, q;
      m = (c < 0) ? longint'(-c) : c;
      q = (m << FB) / len;
      if (q > 64'd2147483648) q = 64'd2147483648;
      return clamp32((c < 0) ? -longint'(q) : longint'(q), sat);
   endfunction

   function automatic vec_result_type vector_result(vec_item_type it);
      longint ax, ay, az, aw, bx, by, bz, bw, s, rx, ry, rz, rw, sc, dx, dy, dz;
      longint unsigned len;
      bit sat, zl;
      vec_result_type r;
      ax = it.ax; ay = it.ay; az = it.az; aw = it.aw;
      bx = it.bx; by = it.by; bz = it.bz; bw = it.bw; s = it.s;
      rx = 0; ry = 0; rz = 0; rw = 0; sc = 0; sat = 0; zl = 0;
      case (it.code)
         OP_ADD: begin
            rx = ax + bx; ry = ay + by; rz = az + bz;
         end
         OP_SUB: begin
            rx = ax - bx; ry = ay - by; rz = az - bz;
         end
         OP_SCALE: begin
            rx = qmul(ax, s); ry = qmul(ay, s); rz = qmul(az, s);
         end
         OP_ELEMMUL: begin
            rx = qmul(ax, bx); ry = qmul(ay, by); rz = qmul(az, bz);
         end
         OP_DOT: sc = qmul(ax, bx) + qmul(ay, by) + qmul(az, bz);
         OP_CROSS: begin
            rx = qmul(ay, bz) - qmul(az, by);
            ry = qmul(az, bx) - qmul(ax, bz);
            rz = qmul(ax, by) - qmul(ay, bx);
         end
         OP_LENGTH: sc = norm3(ax, ay, az);
         OP_NORMALISE: begin
            len = norm3(ax, ay, az);
            if (len == 0) begin
               zl = 1'b1;
            end else begin
               sc = len;
               rx = unit_div(ax, len, sat);
               ry = unit_div(ay, len, sat);
               rz = unit_div(az, len, sat);
            end
         end
         OP_PROJECT: begin
            rx = ax + qmul(bx, s); ry = ay + qmul(by, s); rz = az + qmul(bz, s);
         end
         OP_DISTANCE: begin
            dx = bx - ax; dy = by - ay; dz = bz - az;
            if (dx > P_MAX || dx < -P_MAX || dy > P_MAX || dy < -P_MAX
                || dz > P_MAX || dz < -P_MAX)
               sc = P_MAX + 1;
            else
               sc = norm3(dx, dy, dz);
         end
         OP_LERP: begin
            rx = ax + qmul(bx - ax, s);
            ry = ay + qmul(by - ay, s);
            rz = az + qmul(bz - az, s);
            rw = qmul(aw, bw);
         end
         default: ;
      endcase
      r.rx = 32'(clamp32(rx, sat));
      r.ry = 32'(clamp32(ry, sat));
      r.rz = 32'(clamp32(rz, sat));
      r.rw = 32'(clamp32(rw, sat));
      r.sc = 32'(clamp32(sc, sat));
      r.sat = sat;
      r.zl = zl;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      error_count++;
   endtask

   // result side: random stalls, none in the calm tail
   initial begin
      int gap;
      forever begin
         @(posedge clock);
         if (!sink_calm && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 19);
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      vec_result_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected result item", 1, 0);
         end else begin
            w = expected_q.pop_front();
            if (rsp_tdata[31:0] !== w.rx) report_mismatch("r_x", rsp_tdata[31:0], w.rx);
            if (rsp_tdata[63:32] !== w.ry) report_mismatch("r_y", rsp_tdata[63:32], w.ry);
            if (rsp_tdata[95:64] !== w.rz) report_mismatch("r_z", rsp_tdata[95:64], w.rz);
            if (rsp_tdata[127:96] !== w.rw) report_mismatch("r_w", rsp_tdata[127:96], w.rw);
            if (rsp_tdata[159:128] !== w.sc)
               report_mismatch("scalar_out", rsp_tdata[159:128], w.sc);
            if (rsp_tuser[0] !== w.sat) report_mismatch("saturated", rsp_tuser[0], w.sat);
            if (rsp_tuser[1] !== w.zl) report_mismatch("zero_length", rsp_tuser[1], w.zl);
         end
      end
   end

   // present one item, hold until accepted, queue its expected result
   task automatic send_item(vec_item_type it, bit typed, vec_result_type want);
      vec_result_type p;
      p = vector_result(it);
      if (typed && p != want) begin
         report_mismatch("predictor against table", longint'(p), longint'(want));
      end
      req_tdata <= {it.s, it.bw, it.bz, it.by, it.bx, it.aw, it.az, it.ay, it.ax};
      req_tuser <= it.code;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_q.push_back(typed ? want : p);
   endtask

   function automatic logic [31:0] rand_field(int mode);
      case (mode)
         0: return $urandom();
         1: return $urandom_range(0, 32'h3_ffff) - 32'h2_0000;  // around +-2.0
         2: return $urandom_range(0, 32'h1ff_ffff) - 32'h100_0000;
         3: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
         default: return $urandom_range(0, 1) ? 32'd0 : 32'h0001_0000;
      endcase
   endfunction

   function automatic vec_item_type random_item();
      vec_item_type it;
      int mode;
      it.code = ($urandom_range(0, 24) == 0) ? 4'($urandom_range(11, 15))
                                             : 4'($urandom_range(0, 10));
      mode = $urandom_range(0, 9);
      mode = (mode < 2) ? 0 : (mode < 6) ? 1 : (mode < 8) ? 2 : (mode < 9) ? 3 : 4;
      it.ax = rand_field(mode); it.ay = rand_field(mode); it.az = rand_field(mode);
      it.aw = rand_field(mode); it.bx = rand_field(mode); it.by = rand_field(mode);
      it.bz = rand_field(mode); it.bw = rand_field(mode);
      // fraction for lerp mostly in 0..1
      it.s = (it.code == OP_LERP && $urandom_range(0, 3) != 0)
             ? $urandom_range(0, 32'h1_0000) : rand_field(mode);
      return it;
   endfunction

   function automatic table_row_type row(logic [3:0] c, logic signed [31:0] ax, ay, az, aw,
                                         bx, by, bz, bw, s, bit typed = 0,
                                         logic signed [31:0] rx = 0, ry = 0, rz = 0,
                                         rw = 0, sc = 0, bit sat = 0, bit zl = 0);
      table_row_type t;
      t.it.code = c;
      t.it.ax = ax; t.it.ay = ay; t.it.az = az; t.it.aw = aw;
      t.it.bx = bx; t.it.by = by; t.it.bz = bz; t.it.bw = bw; t.it.s = s;
      t.typed = typed;
      t.res.rx = rx; t.res.ry = ry; t.res.rz = rz; t.res.rw = rw; t.res.sc = sc;
      t.res.sat = sat; t.res.zl = zl;
      return t;
   endfunction

   initial begin
      table_row_type dir_table[$];
      vec_item_type it;
      vec_result_type none;
      int gap;
      none = '0;
      dir_table.push_back(row(OP_ADD, 1, 2, 3, 0, 4, 5, 6, 0, 0, 1, 5, 7, 9));
      dir_table.push_back(row(OP_ADD, 32'h7fffffff, 32'h80000000, 0, 0,
                              1, -1, 0, 0, 0, 1, 32'h7fffffff, 32'h80000000, 0, 0, 0, 1));
      dir_table.push_back(row(OP_SUB, 32'h80000000, 32'h7fffffff, 5, 0,
                              1, -1, 5, 0, 0, 1, 32'h80000000, 32'h7fffffff, 0, 0, 0, 1));
      dir_table.push_back(row(OP_SCALE, 32'h10000, -32'h10000, 32'h7fffffff, 0,
                              0, 0, 0, 0, 32'h20000));
      dir_table.push_back(row(OP_SCALE, -1, 1, 32'h80000000, 0, 0, 0, 0, 0, 32'h8000));
      dir_table.push_back(row(OP_ELEMMUL, 32'h80000000, 32'h7fffffff, -3, 0,
                              32'h80000000, 32'h7fffffff, 32'h18000, 0, 0));
      dir_table.push_back(row(OP_DOT, 32'h10000, 32'h20000, 32'h30000, 0,
                              32'h10000, 32'h10000, 32'h10000, 0, 0,
                              1, 0, 0, 0, 0, 32'h60000));
      dir_table.push_back(row(OP_DOT, 32'h80000000, 32'h80000000, 32'h80000000, 0,
                              32'h80000000, 32'h80000000, 32'h80000000, 0, 0));
      dir_table.push_back(row(OP_CROSS, 32'h10000, 0, 0, 0, 0, 32'h10000, 0, 0, 0,
                              1, 0, 0, 32'h10000));
      dir_table.push_back(row(OP_CROSS, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0,
                              32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0));
      dir_table.push_back(row(OP_LENGTH, 32'h30000, 32'h40000, 0, 0, 0, 0, 0, 0, 0,
                              1, 0, 0, 0, 0, 32'h50000));
      dir_table.push_back(row(OP_LENGTH, 32'h80000000, 32'h80000000, 32'h80000000, 0,
                              0, 0, 0, 0, 0));
      // normalising a zero vector raises zero_length
      dir_table.push_back(row(OP_NORMALISE, 0, 0, 0, 0, 5, 5, 5, 5, 5,
                              1, 0, 0, 0, 0, 0, 0, 1));
      dir_table.push_back(row(OP_NORMALISE, 1, 0, 0, 0, 0, 0, 0, 0, 0));
      dir_table.push_back(row(OP_NORMALISE, -32'h30000, 32'h40000, 0, 0, 0, 0, 0, 0, 0));
      dir_table.push_back(row(OP_NORMALISE, 32'h80000000, 32'h7fffffff, 32'h80000000,
                              0, 0, 0, 0, 0, 0));
      dir_table.push_back(row(OP_PROJECT, 32'h10000, 0, 0, 0, 32'h10000, 32'h7fffffff,
                              32'h80000000, 0, 32'h7fffffff));
      dir_table.push_back(row(OP_DISTANCE, 0, 0, 0, 0, 32'h30000, 0, 32'h40000, 0, 0,
                              1, 0, 0, 0, 0, 32'h50000));
      // a difference of 2^31 or more saturates the distance
      dir_table.push_back(row(OP_DISTANCE, 32'h80000000, 0, 0, 0, 32'h7fffffff, 0, 0, 0, 0,
                              1, 0, 0, 0, 0, 32'h7fffffff, 1));
      dir_table.push_back(row(OP_DISTANCE, 0, 0, 0, 0, 32'h80000000, 32'h80000000,
                              32'h80000000, 0, 0));
      dir_table.push_back(row(OP_LERP, 0, 0, 0, 32'h20000, 32'h20000, 32'h40000,
                              -32'h20000, 32'h30000, 32'h8000,
                              1, 32'h10000, 32'h20000, -32'h10000, 32'h60000));
      dir_table.push_back(row(OP_LERP, 32'h80000000, 32'h7fffffff, 0, 32'h80000000,
                              32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h80000000,
                              32'h80000000));
      dir_table.push_back(row(4'd11, 1, 2, 3, 4, 5, 6, 7, 8, 9, 1));
      dir_table.push_back(row(4'd15, -1, -1, -1, -1, -1, -1, -1, -1, -1, 1));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_table[i])
         send_item(dir_table[i].it, dir_table[i].typed, dir_table[i].res);
      req_tvalid <= 1'b0;
      // hold off until the pipeline has drained
      while (expected_q.size() != 0) @(posedge clock);

      for (int n = 0; n < N_RANDOM; n++) begin
         if (n > N_RANDOM - 200) sink_calm = 1'b1;
         if (!sink_calm && $urandom_range(0, 11) == 0) begin
            gap = $urandom_range(1, 19);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         it = random_item();
         send_item(it, 0, none);
      end
      req_tvalid <= 1'b0;

      while (expected_q.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
